@@ rtl/rppim_pkg.sv @@
// Shared types, constants and the multiply sequence for the ray-parity point-in-mesh block.
// No dependencies; every other file of the block imports this package.
package rppim_pkg;

    // Field and datapath widths
    localparam int CRD_W = 32;      // Q16.16 coordinate
    localparam int DIF_W = 33;      // exact difference of two coordinates
    localparam int EPS_W = 17;      // tolerance register
    localparam int CNT_W = 16;      // hit counter (count bits)
    localparam int CFG_W = 32;      // configuration write data
    localparam int IDX_W = 2;       // configuration register index
    localparam int P_W   = 51;      // p = dir x e2
    localparam int Q_W   = 68;      // q = s x e1
    localparam int ACC_W = 104;     // dot products and eps * den
    localparam int CMP_W = 124;     // dot products scaled by 2^16 for the final tests
    localparam int MPL_W = 33;      // magnitude of a multiplier operand
    localparam int OP_W  = 5;       // micro-op counter

    // Hit counter saturates here
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Ray direction, Q0.16, normalized
    localparam logic [DIF_W-1:0] DIR_X = DIF_W'(48689);
    localparam logic [DIF_W-1:0] DIR_Y = DIF_W'(34928);
    localparam logic [DIF_W-1:0] DIR_Z = DIF_W'(26540);

    // Reset value of the tolerance (about 0.001)
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_POINT_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_POINT_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_POINT_Z = 2'd2;
    localparam logic [IDX_W-1:0] CFG_EPSILON = 2'd3;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // One triangle after set-up: edges, offset of the point, last mark
    typedef struct packed {
        logic signed [DIF_W-1:0] e1x;
        logic signed [DIF_W-1:0] e1y;
        logic signed [DIF_W-1:0] e1z;
        logic signed [DIF_W-1:0] e2x;
        logic signed [DIF_W-1:0] e2y;
        logic signed [DIF_W-1:0] e2z;
        logic signed [DIF_W-1:0] sx;
        logic signed [DIF_W-1:0] sy;
        logic signed [DIF_W-1:0] sz;
        logic                    last;
    } tri_t;

    // Multiplicand sources
    typedef enum logic [3:0] {
        A_E1X, A_E1Y, A_E1Z, A_E2X, A_E2Y, A_E2Z,
        A_P0, A_P1, A_P2, A_Q0, A_Q1, A_Q2, A_DEN
    } asrc_t;

    // Multiplier sources
    typedef enum logic [3:0] {
        B_DX, B_DY, B_DZ, B_SX, B_SY, B_SZ,
        B_E1X, B_E1Y, B_E1Z, B_E2X, B_E2Y, B_E2Z, B_EPS
    } bsrc_t;

    // Destination written at the end of a micro-op
    typedef enum logic [3:0] {
        D_NONE, D_P0, D_P1, D_P2, D_Q0, D_Q1, D_Q2,
        D_DET, D_NU, D_NV, D_NT, D_ED
    } dst_t;

    // acc = (first ? 0 : acc) +/- a * b, then optionally stored
    typedef struct packed {
        asrc_t a;
        bsrc_t b;
        logic  sub;
        logic  first;
        dst_t  dst;
    } uop_t;

    localparam logic [OP_W-1:0] OP_LAST_MAIN = OP_W'(23);
    localparam logic [OP_W-1:0] OP_EPS       = OP_W'(24);

    function automatic uop_t uop_rom(input logic [OP_W-1:0] idx);
        uop_t u;
        u = '{a: A_E1X, b: B_DX, sub: 1'b0, first: 1'b1, dst: D_NONE};
        unique case (idx)
            // p = dir x e2
            5'd0:  u = '{A_E2Z, B_DY,  1'b0, 1'b1, D_NONE};
            5'd1:  u = '{A_E2Y, B_DZ,  1'b1, 1'b0, D_P0};
            5'd2:  u = '{A_E2X, B_DZ,  1'b0, 1'b1, D_NONE};
            5'd3:  u = '{A_E2Z, B_DX,  1'b1, 1'b0, D_P1};
            5'd4:  u = '{A_E2Y, B_DX,  1'b0, 1'b1, D_NONE};
            5'd5:  u = '{A_E2X, B_DY,  1'b1, 1'b0, D_P2};
            // q = s x e1
            5'd6:  u = '{A_E1Z, B_SY,  1'b0, 1'b1, D_NONE};
            5'd7:  u = '{A_E1Y, B_SZ,  1'b1, 1'b0, D_Q0};
            5'd8:  u = '{A_E1X, B_SZ,  1'b0, 1'b1, D_NONE};
            5'd9:  u = '{A_E1Z, B_SX,  1'b1, 1'b0, D_Q1};
            5'd10: u = '{A_E1Y, B_SX,  1'b0, 1'b1, D_NONE};
            5'd11: u = '{A_E1X, B_SY,  1'b1, 1'b0, D_Q2};
            // det = e1 . p
            5'd12: u = '{A_P0,  B_E1X, 1'b0, 1'b1, D_NONE};
            5'd13: u = '{A_P1,  B_E1Y, 1'b0, 1'b0, D_NONE};
            5'd14: u = '{A_P2,  B_E1Z, 1'b0, 1'b0, D_DET};
            // nu = s . p
            5'd15: u = '{A_P0,  B_SX,  1'b0, 1'b1, D_NONE};
            5'd16: u = '{A_P1,  B_SY,  1'b0, 1'b0, D_NONE};
            5'd17: u = '{A_P2,  B_SZ,  1'b0, 1'b0, D_NU};
            // nv = dir . q
            5'd18: u = '{A_Q0,  B_DX,  1'b0, 1'b1, D_NONE};
            5'd19: u = '{A_Q1,  B_DY,  1'b0, 1'b0, D_NONE};
            5'd20: u = '{A_Q2,  B_DZ,  1'b0, 1'b0, D_NV};
            // nt = e2 . q
            5'd21: u = '{A_Q0,  B_E2X, 1'b0, 1'b1, D_NONE};
            5'd22: u = '{A_Q1,  B_E2Y, 1'b0, 1'b0, D_NONE};
            5'd23: u = '{A_Q2,  B_E2Z, 1'b0, 1'b0, D_NT};
            // ed = eps * |det|
            5'd24: u = '{A_DEN, B_EPS, 1'b0, 1'b1, D_ED};
            default: u = '{A_E1X, B_DX, 1'b0, 1'b1, D_NONE};
        endcase
        return u;
    endfunction

    // Sign-extend an accumulator value to the compare width
    function automatic logic signed [CMP_W-1:0] sxc(input logic signed [ACC_W-1:0] v);
        return CMP_W'(v);
    endfunction

endpackage

@@ rtl/rppim_front.sv @@
// Front end: accepts triangle beats and forms edges and point offset.
// Depends on rppim_pkg.
module rppim_front (
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [rppim_pkg::CRD_W-1:0] ax,
    input  logic signed [rppim_pkg::CRD_W-1:0] ay,
    input  logic signed [rppim_pkg::CRD_W-1:0] az,
    input  logic signed [rppim_pkg::CRD_W-1:0] bx,
    input  logic signed [rppim_pkg::CRD_W-1:0] by,
    input  logic signed [rppim_pkg::CRD_W-1:0] bz,
    input  logic signed [rppim_pkg::CRD_W-1:0] cx,
    input  logic signed [rppim_pkg::CRD_W-1:0] cy,
    input  logic signed [rppim_pkg::CRD_W-1:0] cz,
    input  logic                            last_triangle,
    input  logic signed [rppim_pkg::CRD_W-1:0] point_x,
    input  logic signed [rppim_pkg::CRD_W-1:0] point_y,
    input  logic signed [rppim_pkg::CRD_W-1:0] point_z,
    output logic                            push,
    output rppim_pkg::tri_t                 push_data,
    input  logic                            q_ready
);
    import rppim_pkg::*;

    // Beat handshake follows queue space
    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

    // Exact 33-bit differences
    always_comb
    begin
        push_data.e1x  = DIF_W'(bx) - DIF_W'(ax);
        push_data.e1y  = DIF_W'(by) - DIF_W'(ay);
        push_data.e1z  = DIF_W'(bz) - DIF_W'(az);
        push_data.e2x  = DIF_W'(cx) - DIF_W'(ax);
        push_data.e2y  = DIF_W'(cy) - DIF_W'(ay);
        push_data.e2z  = DIF_W'(cz) - DIF_W'(az);
        push_data.sx   = DIF_W'(point_x) - DIF_W'(ax);
        push_data.sy   = DIF_W'(point_y) - DIF_W'(ay);
        push_data.sz   = DIF_W'(point_z) - DIF_W'(az);
        push_data.last = last_triangle;
    end

endmodule

@@ rtl/rppim_queue.sv @@
// Short queue of prepared triangles between front and back end.
// Depends on rppim_pkg.
module rppim_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rppim_pkg::tri_t push_data,
    output logic            q_ready,
    output logic            q_valid,
    input  logic            pop,
    output rppim_pkg::tri_t q_data
);
    import rppim_pkg::*;

    tri_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;

    assign q_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == Q_CW'(Q_DEPTH))) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0)) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");

endmodule

@@ rtl/rppim_back.sv @@
// Back end: bit-serial multiply-accumulate sequencer for the ray/triangle test,
// hit counter and result register. Depends on rppim_pkg.
module rppim_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          pop,
    input  rppim_pkg::tri_t               q_data,
    input  logic [rppim_pkg::EPS_W-1:0]   epsilon,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic [rppim_pkg::CNT_W-1:0]   hit_count
);
    import rppim_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RUN, S_FIX, S_CMP1, S_CMP2, S_DONE
    } state_t;

    state_t                     state_reg;
    logic [OP_W-1:0]            op_reg;
    tri_t                       tri_reg;
    logic signed [ACC_W-1:0]    mcand_reg;
    logic [MPL_W-1:0]           mplier_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [P_W-1:0]      p0_reg, p1_reg, p2_reg;
    logic signed [Q_W-1:0]      q0_reg, q1_reg, q2_reg;
    logic signed [ACC_W-1:0]    det_reg, nu_reg, nv_reg, nt_reg, den_reg, ed_reg;
    logic signed [CMP_W-1:0]    od_reg, suv_reg, st_reg;
    logic                       hit_reg;
    logic [CNT_W-1:0]           hits_reg;
    logic                       out_valid_reg;
    logic                       inside_reg;
    logic [CNT_W-1:0]           count_out_reg;

    uop_t                       uop;
    logic signed [ACC_W-1:0]    a_val;
    logic signed [DIF_W-1:0]    b_val;
    logic                       b_neg;
    logic [MPL_W-1:0]           b_mag;
    logic signed [CMP_W-1:0]    su_c, sv_c, ed_c, den_c, eps_c;
    logic [CNT_W-1:0]           hits_next;
    logic                       out_free;
    logic                       emit;

    assign uop      = uop_rom(op_reg);
    assign pop      = (state_reg == S_IDLE) && q_valid;
    assign out_free = !out_valid_reg || out_ready;
    assign emit     = (state_reg == S_DONE) && tri_reg.last && out_free;

    // Multiplicand select
    always_comb
    begin
        case (uop.a)
            A_E1X:   a_val = ACC_W'(tri_reg.e1x);
            A_E1Y:   a_val = ACC_W'(tri_reg.e1y);
            A_E1Z:   a_val = ACC_W'(tri_reg.e1z);
            A_E2X:   a_val = ACC_W'(tri_reg.e2x);
            A_E2Y:   a_val = ACC_W'(tri_reg.e2y);
            A_E2Z:   a_val = ACC_W'(tri_reg.e2z);
            A_P0:    a_val = ACC_W'(p0_reg);
            A_P1:    a_val = ACC_W'(p1_reg);
            A_P2:    a_val = ACC_W'(p2_reg);
            A_Q0:    a_val = ACC_W'(q0_reg);
            A_Q1:    a_val = ACC_W'(q1_reg);
            A_Q2:    a_val = ACC_W'(q2_reg);
            A_DEN:   a_val = den_reg;
            default: a_val = '0;
        endcase
    end

    // Multiplier select
    always_comb
    begin
        case (uop.b)
            B_DX:    b_val = signed'(DIR_X);
            B_DY:    b_val = signed'(DIR_Y);
            B_DZ:    b_val = signed'(DIR_Z);
            B_SX:    b_val = tri_reg.sx;
            B_SY:    b_val = tri_reg.sy;
            B_SZ:    b_val = tri_reg.sz;
            B_E1X:   b_val = tri_reg.e1x;
            B_E1Y:   b_val = tri_reg.e1y;
            B_E1Z:   b_val = tri_reg.e1z;
            B_E2X:   b_val = tri_reg.e2x;
            B_E2Y:   b_val = tri_reg.e2y;
            B_E2Z:   b_val = tri_reg.e2z;
            B_EPS:   b_val = signed'(DIF_W'(epsilon));
            default: b_val = '0;
        endcase
    end

    // Sign of the product goes to the multiplicand, magnitude is shifted out
    assign b_neg = b_val[DIF_W-1] ^ uop.sub;
    assign b_mag = b_val[DIF_W-1] ? MPL_W'(-b_val) : MPL_W'(b_val);

    // Final test operands: su_c, sv_c and ed_c in units of 2^-64, den_c and eps_c in units of 2^-48
    assign su_c  = sxc(nu_reg) <<< 16;
    assign sv_c  = sxc(nv_reg) <<< 16;
    assign ed_c  = sxc(ed_reg);
    assign den_c = sxc(den_reg);
    assign eps_c = signed'(CMP_W'({epsilon, 32'd0}));

    // Saturating hit count including the current triangle
    assign hits_next = (hit_reg && hits_reg != CNT_MAX) ? hits_reg + 1'b1 : hits_reg;

    // Sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            // Result beat: set on a last triangle, cleared when taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        tri_reg   <= q_data;
                        op_reg    <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    mcand_reg  <= b_neg ? -a_val : a_val;
                    mplier_reg <= b_mag;
                    if (uop.first)
                    begin
                        acc_reg <= '0;
                    end
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (mplier_reg == '0)
                    begin
                        unique case (uop.dst)
                            D_P0:   p0_reg <= acc_reg[P_W-1:0];
                            D_P1:   p1_reg <= acc_reg[P_W-1:0];
                            D_P2:   p2_reg <= acc_reg[P_W-1:0];
                            D_Q0:   q0_reg <= acc_reg[Q_W-1:0];
                            D_Q1:   q1_reg <= acc_reg[Q_W-1:0];
                            D_Q2:   q2_reg <= acc_reg[Q_W-1:0];
                            D_DET:  det_reg <= acc_reg;
                            D_NU:   nu_reg <= acc_reg;
                            D_NV:   nv_reg <= acc_reg;
                            D_NT:   nt_reg <= acc_reg;
                            D_ED:   ed_reg <= acc_reg;
                            default: ;
                        endcase
                        if (op_reg == OP_LAST_MAIN)
                        begin
                            state_reg <= S_FIX;
                        end
                        else if (op_reg == OP_EPS)
                        begin
                            state_reg <= S_CMP1;
                        end
                        else
                        begin
                            op_reg    <= op_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_reg + mcand_reg;
                        end
                        mcand_reg  <= mcand_reg <<< 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                S_FIX:
                begin
                    // Fold the sign of det into the numerators
                    if (det_reg[ACC_W-1])
                    begin
                        den_reg <= -det_reg;
                        nu_reg  <= -nu_reg;
                        nv_reg  <= -nv_reg;
                        nt_reg  <= -nt_reg;
                    end
                    else
                    begin
                        den_reg <= det_reg;
                    end
                    op_reg    <= OP_EPS;
                    state_reg <= S_LOAD;
                end
                S_CMP1:
                begin
                    od_reg    <= ed_c + (den_c <<< 16);
                    suv_reg   <= (sxc(nu_reg) + sxc(nv_reg)) <<< 16;
                    st_reg    <= sxc(nt_reg) <<< 16;
                    state_reg <= S_CMP2;
                end
                S_CMP2:
                begin
                    hit_reg <= (eps_c < den_c)
                        && !(su_c < -ed_c) && !(od_reg < su_c)
                        && !(sv_c < -ed_c) && !(od_reg < suv_reg)
                        && (ed_c < st_reg);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!tri_reg.last)
                    begin
                        hits_reg  <= hits_next;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        inside_reg    <= hits_next[0];
                        count_out_reg <= hits_next;
                        hits_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign hit_count  = count_out_reg;

endmodule

@@ rtl/ray_parity_point_in_mesh.sv @@
// Top level of the ray-parity point-in-mesh block: configuration registers,
// front end, queue and back end. Depends on rppim_pkg and the rppim_* modules.
//
// Each triangle beat is tested against a ray from the configured point along a
// fixed oblique direction; hits are counted (saturating) and a beat marked
// last_triangle yields one result with the count and its parity, after which the
// count restarts. The back end works on one triangle at a time, data dependent:
// 25 multiply steps run on one bit-serial multiply-accumulate unit, each a load,
// then one multiplier bit per cycle up to the highest set multiplier bit, then a
// store, plus the steps to take the triangle, fix the sign, compare and count. A
// last triangle also waits while a previous result is still held by out_ready.
// The queue holds two prepared triangles, so beats are taken while the back end
// is busy and while a result waits on out_ready, until the queue is full. Write
// configuration only while the block is idle.
module ray_parity_point_in_mesh (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rppim_pkg::IDX_W-1:0]        cfg_index,
    input  logic [rppim_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rppim_pkg::CRD_W-1:0] ax,
    input  logic signed [rppim_pkg::CRD_W-1:0] ay,
    input  logic signed [rppim_pkg::CRD_W-1:0] az,
    input  logic signed [rppim_pkg::CRD_W-1:0] bx,
    input  logic signed [rppim_pkg::CRD_W-1:0] by,
    input  logic signed [rppim_pkg::CRD_W-1:0] bz,
    input  logic signed [rppim_pkg::CRD_W-1:0] cx,
    input  logic signed [rppim_pkg::CRD_W-1:0] cy,
    input  logic signed [rppim_pkg::CRD_W-1:0] cz,
    input  logic                               last_triangle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               inside_res,
    output logic [rppim_pkg::CNT_W-1:0]        hit_count
);
    import rppim_pkg::*;

    logic signed [CRD_W-1:0] point_x_reg, point_y_reg, point_z_reg;
    logic [EPS_W-1:0]        epsilon_reg;
    logic                    push, q_ready, q_valid, pop;
    tri_t                    push_data, q_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            point_z_reg <= '0;
            epsilon_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POINT_X: point_x_reg <= cfg_data;
                CFG_POINT_Y: point_y_reg <= cfg_data;
                CFG_POINT_Z: point_z_reg <= cfg_data;
                CFG_EPSILON: epsilon_reg <= cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    rppim_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ax            (ax),
        .ay            (ay),
        .az            (az),
        .bx            (bx),
        .by            (by),
        .bz            (bz),
        .cx            (cx),
        .cy            (cy),
        .cz            (cz),
        .last_triangle (last_triangle),
        .point_x       (point_x_reg),
        .point_y       (point_y_reg),
        .point_z       (point_z_reg),
        .push          (push),
        .push_data     (push_data),
        .q_ready       (q_ready)
    );

    rppim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .pop       (pop),
        .q_data    (q_data)
    );

    rppim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .pop        (pop),
        .q_data     (q_data),
        .epsilon    (epsilon_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .hit_count  (hit_count)
    );

endmodule
